// ===== design/assert_macros.svh =====
// Assertion macros shared by the heap priority queue RTL.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is switched off while reset is high.
`define HMPQ_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Clocked check that also runs while reset is high.
`define HMPQ_ASSERT_NR(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) \
      else $error(msg);

`endif

// ===== design/hmpq_pkg.sv =====
// Types and constants of the heap priority queue.
// No dependencies; used by the interfaces and all modules.
`default_nettype none

package hmpq_pkg;

   localparam int DATA_W = 32;

   typedef logic signed [DATA_W-1:0] data_type;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_REMOVE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef enum logic {
      CMP_UP = 1'b0,
      CMP_DN = 1'b1
   } cmp_mode_type;

   typedef struct packed {
      logic     sel_right;
      logic     move;
      data_type win;
   } cmp_res_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UP_RD,
      ST_UP_CMP,
      ST_DN_LAST,
      ST_DN_RD,
      ST_DN_CMP,
      ST_PLACE,
      ST_FINISH
   } state_type;

endpackage

`default_nettype wire

// ===== design/hmpq_req_if.sv =====
// Request channel of the heap priority queue: valid/ready plus one request word.
// Depends on hmpq_pkg.
`default_nettype none

interface hmpq_req_if ();
   import hmpq_pkg::*;

   logic     valid;
   logic     ready;
   op_type   operation;
   data_type value;

   modport source (output valid, output operation, output value, input ready);
   modport sink   (input valid, input operation, input value, output ready);
endinterface

`default_nettype wire

// ===== design/hmpq_rsp_if.sv =====
// Response channel of the heap priority queue: valid/ready plus one result word.
// Depends on hmpq_pkg.
`default_nettype none

interface hmpq_rsp_if #(
   parameter int COUNT_W = 7
) ();
   import hmpq_pkg::*;

   logic               valid;
   logic               ready;
   data_type           removed_value;
   data_type           top_value;
   logic [COUNT_W-1:0] entry_count;
   logic               is_empty;
   status_type         status;

   modport source (output valid, output removed_value, output top_value,
                   output entry_count, output is_empty, output status, input ready);
   modport sink   (input valid, input removed_value, input top_value,
                   input entry_count, input is_empty, input status, output ready);
endinterface

`default_nettype wire

// ===== design/hmpq_store.sv =====
// Heap entry memory: one write port and two registered read ports.
// Depends on hmpq_pkg.
`default_nettype none

module hmpq_store #(
   parameter int DEPTH  = 64,
   parameter int ADDR_W = 6
) (
   input  wire logic               clock,
   input  wire logic               wr_en,
   input  wire logic [ADDR_W-1:0]  wr_addr,
   input  wire hmpq_pkg::data_type wr_data,
   input  wire logic [ADDR_W-1:0]  rd_addr0,
   input  wire logic [ADDR_W-1:0]  rd_addr1,
   output hmpq_pkg::data_type      rd_data0,
   output hmpq_pkg::data_type      rd_data1
);
   import hmpq_pkg::*;

   data_type mem [DEPTH];
   data_type rd_data0_ff;
   data_type rd_data1_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data0_ff <= mem[rd_addr0];
      rd_data1_ff <= mem[rd_addr1];
   end

   assign rd_data0 = rd_data0_ff;
   assign rd_data1 = rd_data1_ff;

endmodule

`default_nettype wire

// ===== design/hmpq_cmp.sv =====
// Shared compare unit: picks the larger child and decides whether the hole moves.
// Depends on hmpq_pkg.
`default_nettype none

module hmpq_cmp (
   input  wire hmpq_pkg::cmp_mode_type mode,
   input  wire hmpq_pkg::data_type     hole,
   input  wire hmpq_pkg::data_type     left_val,
   input  wire hmpq_pkg::data_type     right_val,
   input  wire logic                   right_ok,
   output hmpq_pkg::cmp_res_type       res
);
   import hmpq_pkg::*;

   data_type op_a;
   data_type op_b;
   data_type win;
   logic     sel_right;

   // On the way down the left child wins a tie; on the way up only one entry is seen.
   assign sel_right = (mode == CMP_DN) && right_ok && (right_val > left_val);
   assign win       = sel_right ? right_val : left_val;

   // Going up the new value must beat its parent; going down the child must beat the hole.
   assign op_a = (mode == CMP_UP) ? hole : win;
   assign op_b = (mode == CMP_UP) ? win  : hole;

   assign res.sel_right = sel_right;
   assign res.move      = (op_a > op_b);
   assign res.win       = win;

endmodule

`default_nettype wire

// ===== design/max_heap_priority_queue.sv =====
// Binary max-heap priority queue of signed 32-bit words; one response word per request word.
// Throughput: one request word at a time, taken only once the previous response word
// is registered; set by the single comparator and the registered memory read.
// Synchronous active-high reset empties the heap and clears the handshakes; the entry
// memory itself is left as it is.
`default_nettype none
`include "assert_macros.svh"

module max_heap_priority_queue #(
   parameter int CAPACITY = 64
) (
   input  wire logic   clock,
   input  wire logic   reset,
   hmpq_req_if.sink    req_bus,
   hmpq_rsp_if.source  rsp_bus
);
   import hmpq_pkg::*;

   // Address width covers the entries; count width also holds CAPACITY itself.
   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [CW-1:0] CAP_COUNT = CW'(CAPACITY);

   // Sequencer state and the working registers of one operation.
   state_type         state_ff, state_in;
   logic [AW-1:0]     pos_ff, pos_in;
   data_type          hole_ff, hole_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              right_ok_ff, right_ok_in;
   data_type          removed_ff, removed_in;
   status_type        status_ff, status_in;
   data_type          top_ff;

   // Output register holding the finished response word.
   logic              rsp_valid_ff, rsp_valid_in;
   data_type          out_removed_ff, out_removed_in;
   data_type          out_top_ff, out_top_in;
   logic [CW-1:0]     out_count_ff, out_count_in;
   logic              out_empty_ff, out_empty_in;
   status_type        out_status_ff, out_status_in;

   // Memory and compare unit hookup.
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   data_type          wr_data;
   logic [AW-1:0]     rd_addr0;
   logic [AW-1:0]     rd_addr1;
   data_type          rd_data0;
   data_type          rd_data1;
   cmp_mode_type      cmp_mode;
   cmp_res_type       cmp_res;

   // Tree arithmetic on the current hole position.
   logic [AW-1:0]     parent_idx;
   logic [AW+1:0]     left_w;
   logic [AW+1:0]     right_w;
   logic [AW+1:0]     count_w;
   logic [CW-1:0]     count_dec;

   assign parent_idx = (pos_ff - AW'(1)) >> 1;
   assign left_w     = {1'b0, pos_ff, 1'b1};
   assign right_w    = left_w + (AW+2)'(1);
   assign count_w    = (AW+2)'(count_ff);
   assign count_dec  = count_ff - CW'(1);

   hmpq_store #(
      .DEPTH  (CAPACITY),
      .ADDR_W (AW)
   ) u_store (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd_addr0 (rd_addr0),
      .rd_addr1 (rd_addr1),
      .rd_data0 (rd_data0),
      .rd_data1 (rd_data1)
   );

   hmpq_cmp u_cmp (
      .mode      (cmp_mode),
      .hole      (hole_ff),
      .left_val  (rd_data0),
      .right_val (rd_data1),
      .right_ok  (right_ok_ff),
      .res       (cmp_res)
   );

   // A request word is taken only while the sequencer is idle and out of reset.
   assign req_bus.ready = (state_ff == ST_IDLE) && !reset;

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.removed_value = out_removed_ff;
   assign rsp_bus.top_value     = out_top_ff;
   assign rsp_bus.entry_count   = out_count_ff;
   assign rsp_bus.is_empty      = out_empty_ff;
   assign rsp_bus.status        = out_status_ff;

   // The sequencer moves a hole through the tree instead of swapping pairs. An insert
   // carries the new word up, pulling each smaller parent down one level; a remove
   // carries the last entry down from the root, pulling the larger child up. Every
   // level reads the memory in one state and compares and writes back in the state after it.
   always_comb begin
      state_in       = state_ff;
      pos_in         = pos_ff;
      hole_in        = hole_ff;
      count_in       = count_ff;
      right_ok_in    = right_ok_ff;
      removed_in     = removed_ff;
      status_in      = status_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_bus.ready;
      out_removed_in = out_removed_ff;
      out_top_in     = out_top_ff;
      out_count_in   = out_count_ff;
      out_empty_in   = out_empty_ff;
      out_status_in  = out_status_ff;
      wr_en          = 1'b0;
      wr_addr        = pos_ff;
      wr_data        = hole_ff;
      rd_addr0       = '0;
      rd_addr1       = '0;
      cmp_mode       = CMP_UP;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               removed_in = '0;
               status_in  = STATUS_OK;
               if (req_bus.operation == OP_INSERT) begin
                  if (count_ff == CAP_COUNT) begin
                     status_in = STATUS_FULL;
                     state_in  = ST_FINISH;
                  end else begin
                     // The new word starts in the first free slot.
                     hole_in  = req_bus.value;
                     pos_in   = count_ff[AW-1:0];
                     count_in = count_ff + CW'(1);
                     state_in = (count_ff == '0) ? ST_PLACE : ST_UP_RD;
                  end
               end else begin
                  if (count_ff == '0) begin
                     status_in = STATUS_EMPTY;
                     state_in  = ST_FINISH;
                  end else begin
                     // The root leaves; fetch the last entry to refill it.
                     removed_in = top_ff;
                     count_in   = count_dec;
                     rd_addr0   = count_dec[AW-1:0];
                     state_in   = (count_dec == '0) ? ST_FINISH : ST_DN_LAST;
                  end
               end
            end
         end
         ST_UP_RD: begin
            rd_addr0 = parent_idx;
            state_in = ST_UP_CMP;
         end
         ST_UP_CMP: begin
            cmp_mode = CMP_UP;
            wr_en    = 1'b1;
            if (cmp_res.move) begin
               wr_data  = rd_data0;
               pos_in   = parent_idx;
               state_in = (parent_idx == '0) ? ST_PLACE : ST_UP_RD;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_DN_LAST: begin
            hole_in  = rd_data0;
            pos_in   = '0;
            state_in = ST_DN_RD;
         end
         ST_DN_RD: begin
            if (left_w >= count_w) begin
               state_in = ST_PLACE;
            end else begin
               rd_addr0    = left_w[AW-1:0];
               rd_addr1    = right_w[AW-1:0];
               right_ok_in = (right_w < count_w);
               state_in    = ST_DN_CMP;
            end
         end
         ST_DN_CMP: begin
            cmp_mode = CMP_DN;
            wr_en    = 1'b1;
            if (cmp_res.move) begin
               wr_data  = cmp_res.win;
               pos_in   = cmp_res.sel_right ? right_w[AW-1:0] : left_w[AW-1:0];
               state_in = ST_DN_RD;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_PLACE: begin
            wr_en    = 1'b1;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            // Wait here only if the previous response word is still unclaimed.
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in   = 1'b1;
               out_removed_in = removed_ff;
               out_top_in     = (count_ff != '0) ? top_ff : '0;
               out_count_in   = count_ff;
               out_empty_in   = (count_ff == '0);
               out_status_in  = status_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
      end else begin
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers; the root copy follows every write that lands on slot zero.
   always_ff @(posedge clock) begin
      pos_ff         <= pos_in;
      hole_ff        <= hole_in;
      right_ok_ff    <= right_ok_in;
      removed_ff     <= removed_in;
      status_ff      <= status_in;
      out_removed_ff <= out_removed_in;
      out_top_ff     <= out_top_in;
      out_count_ff   <= out_count_in;
      out_empty_ff   <= out_empty_in;
      out_status_ff  <= out_status_in;
      if (wr_en && (wr_addr == '0)) begin
         top_ff <= wr_data;
      end
   end

   `HMPQ_ASSERT(a_count_bound, clock, reset, count_ff <= CAP_COUNT, "entry count above capacity")
   `HMPQ_ASSERT(a_one_at_a_time, clock, reset, (req_bus.valid && req_bus.ready) |=> !req_bus.ready, "request taken while busy")
   `HMPQ_ASSERT(a_rsp_from_finish, clock, reset, $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_FINISH), "response word without finish")
   `HMPQ_ASSERT(a_full_reject, clock, reset, (state_ff == ST_FINISH && status_ff == STATUS_FULL) |-> (count_ff == CAP_COUNT), "full status with room left")
   `HMPQ_ASSERT_NR(a_reset_idle, clock, reset |=> (!rsp_bus.valid && state_ff == ST_IDLE), "not idle after reset")

endmodule

`default_nettype wire

// ===== verif/max_heap_priority_queue_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the max-heap priority queue: it drives request words, predicts
// every response word with its own heap model and compares them field by field.
// Depends on hmpq_pkg, hmpq_req_if, hmpq_rsp_if and max_heap_priority_queue.

module max_heap_priority_queue_tb;
   import hmpq_pkg::*;

   localparam int CAPACITY    = 64;
   localparam int COUNT_W     = 7;
   // Limit for the whole run, set well above what the slowest correct run needs.
   localparam int CYCLE_LIMIT = 300000;
   // Extra wait after the last response word; it leaves a margin on top of the longest remove walk.
   localparam int DRAIN_WAIT  = 40;

   // One predicted response word.
   typedef struct {
      data_type           removed_value;
      data_type           top_value;
      logic [COUNT_W-1:0] entry_count;
      logic               is_empty;
      status_type         status;
   } heap_reply_type;

   logic clock = 1'b0;
   logic reset;

   hmpq_req_if                      req_bus ();
   hmpq_rsp_if #(.COUNT_W(COUNT_W)) rsp_bus ();

   max_heap_priority_queue #(.CAPACITY(CAPACITY)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always #1 clock = ~clock;

   // Our own copy of the heap, updated at the moment each request word is accepted.
   data_type       heap_model [CAPACITY];
   int unsigned    heap_size;
   heap_reply_type predicted_replies [$];

   int  error_count;
   int  cycle_count;
   bit  idle_enable;
   int  stall_left;

   // Applies one request to the heap model and returns the response word it must produce.
   // Comparisons are strict, so equal values never trade places; on a tie between the
   // two children the left one is taken.
   function automatic heap_reply_type apply_to_heap_model(op_type op, data_type val);
      heap_reply_type reply;
      int unsigned    pos;
      int unsigned    parent;
      int unsigned    left;
      int unsigned    big;
      data_type       held;
      bit             settled;
      reply.removed_value = '0;
      reply.status        = STATUS_OK;
      settled             = 1'b0;
      if (op == OP_INSERT) begin
         if (heap_size >= CAPACITY) begin
            reply.status = STATUS_FULL;
         end else begin
            pos             = heap_size;
            heap_model[pos] = val;
            heap_size++;
            while (pos > 0 && !settled) begin
               parent = (pos - 1) / 2;
               if (heap_model[pos] > heap_model[parent]) begin
                  held               = heap_model[pos];
                  heap_model[pos]    = heap_model[parent];
                  heap_model[parent] = held;
                  pos                = parent;
               end else begin
                  settled = 1'b1;
               end
            end
         end
      end else if (heap_size == 0) begin
         reply.status = STATUS_EMPTY;
      end else begin
         reply.removed_value = heap_model[0];
         heap_size--;
         heap_model[0] = heap_model[heap_size];
         pos           = 0;
         while (2 * pos + 1 < heap_size && !settled) begin
            left = 2 * pos + 1;
            big  = left;
            if (left + 1 < heap_size && heap_model[left + 1] > heap_model[left]) begin
               big = left + 1;
            end
            if (heap_model[big] > heap_model[pos]) begin
               held            = heap_model[pos];
               heap_model[pos] = heap_model[big];
               heap_model[big] = held;
               pos             = big;
            end else begin
               settled = 1'b1;
            end
         end
      end
      reply.top_value   = (heap_size > 0) ? heap_model[0] : '0;
      reply.entry_count = COUNT_W'(heap_size);
      reply.is_empty    = (heap_size == 0);
      return reply;
   endfunction

   // Length of an idle burst before the next request word; most words get none.
   function automatic int request_gap();
      if (!idle_enable || $urandom_range(0, 3) != 0) begin
         return 0;
      end
      return $urandom_range(1, 18);
   endfunction

   // Random value drawn from one of three shapes: the whole range, a narrow band around
   // zero that makes ties frequent, or the signed extremes and their neighbors.
   function automatic data_type pick_value();
      int unsigned shape;
      shape = $urandom_range(0, 9);
      if (shape < 6) begin
         return data_type'($urandom);
      end else if (shape < 9) begin
         return data_type'($signed($urandom_range(0, 8)) - 4);
      end
      case ($urandom_range(0, 3))
         0: begin
            return 32'sh7FFF_FFFF;
         end
         1: begin
            return 32'sh8000_0000;
         end
         2: begin
            return 32'sh7FFF_FFFE;
         end
         default: begin
            return 32'sh8000_0001;
         end
      endcase
   endfunction

   // Sends one request word. It is entered and left just after a falling edge; valid stays
   // high between back-to-back words, so it gets one assignment per time step at most.
   // The prediction is made at the accepting edge, before any response to it can appear.
   task automatic send_word(op_type op, data_type val);
      int gap;
      gap = request_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.operation <= op;
      req_bus.value     <= val;
      do begin
         @(posedge clock);
      end while (!req_bus.ready);
      predicted_replies = {predicted_replies, apply_to_heap_model(op, val)};
      @(negedge clock);
   endtask

   // Removes from an empty heap right after reset: both must be flagged and return zero.
   task automatic test_remove_when_empty();
      send_word(OP_REMOVE, 32'sd0);
      send_word(OP_REMOVE, -32'sd1);
   endtask

   // Signed extremes, zero and minus one, including a tie at the top, then drains the
   // heap so every one of them comes back out in descending order.
   task automatic test_value_extremes();
      send_word(OP_INSERT, 32'sd0);
      send_word(OP_INSERT, 32'sh8000_0000);
      send_word(OP_INSERT, 32'sh7FFF_FFFF);
      send_word(OP_INSERT, -32'sd1);
      send_word(OP_INSERT, 32'sd1);
      send_word(OP_INSERT, 32'sh7FFF_FFFF);
      repeat (6) begin
         send_word(OP_REMOVE, data_type'($urandom));
      end
   endtask

   // Equal values with one smaller value, then one more remove than the heap holds.
   task automatic test_equal_values();
      send_word(OP_INSERT, 32'sd5);
      send_word(OP_INSERT, 32'sd5);
      send_word(OP_INSERT, 32'sd5);
      send_word(OP_INSERT, -32'sd5);
      repeat (5) begin
         send_word(OP_REMOVE, 32'sd0);
      end
   endtask

   // Fills the heap to capacity, pushes a few rejected inserts, then drains it and asks
   // for a few more removes than it holds. Inserts carry random content throughout.
   task automatic test_fill_and_drain();
      while (heap_size < CAPACITY) begin
         send_word(OP_INSERT, pick_value());
      end
      repeat ($urandom_range(2, 4)) begin
         send_word(OP_INSERT, pick_value());
      end
      while (heap_size > 0) begin
         send_word(OP_REMOVE, data_type'($urandom));
      end
      repeat ($urandom_range(1, 3)) begin
         send_word(OP_REMOVE, data_type'($urandom));
      end
   endtask

   // Random mix whose insert share drifts between phases, so the heap climbs, sinks and
   // hovers at every depth, sometimes hitting full or empty along the way.
   task automatic test_random_mix(int words);
      int insert_pct;
      insert_pct = 50;
      for (int i = 0; i < words; i++) begin
         if (i % 40 == 0) begin
            insert_pct = $urandom_range(25, 80);
         end
         if ($urandom_range(0, 99) < insert_pct) begin
            send_word(OP_INSERT, pick_value());
         end else begin
            send_word(OP_REMOVE, data_type'($urandom));
         end
      end
   endtask

   // The response side holds ready low in random bursts while idling is enabled.
   always @(negedge clock) begin
      if (!idle_enable) begin
         stall_left    <= 0;
         rsp_bus.ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left    <= stall_left - 1;
         rsp_bus.ready <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
         stall_left    <= $urandom_range(0, 17);
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // Every accepted response word is checked against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (predicted_replies.size() == 0) begin
            $error("response word with no request waiting for it");
            error_count++;
         end else begin
            heap_reply_type want;
            want = predicted_replies.pop_front();
            if (rsp_bus.removed_value !== want.removed_value) begin
               $error("removed_value: expected %0d, actual %0d",
                      want.removed_value, rsp_bus.removed_value);
               error_count++;
            end
            if (rsp_bus.top_value !== want.top_value) begin
               $error("top_value: expected %0d, actual %0d",
                      want.top_value, rsp_bus.top_value);
               error_count++;
            end
            if (rsp_bus.entry_count !== want.entry_count) begin
               $error("entry_count: expected %0d, actual %0d",
                      want.entry_count, rsp_bus.entry_count);
               error_count++;
            end
            if (rsp_bus.is_empty !== want.is_empty) begin
               $error("is_empty: expected %0b, actual %0b", want.is_empty, rsp_bus.is_empty);
               error_count++;
            end
            if (rsp_bus.status !== want.status) begin
               $error("status: expected %s, actual %s",
                      want.status.name(), rsp_bus.status.name());
               error_count++;
            end
         end
      end
   end

   // Watchdog: a hang anywhere ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.operation = OP_INSERT;
      req_bus.value     = '0;
      rsp_bus.ready     = 1'b0;
      idle_enable       = 1'b1;
      stall_left        = 0;
      error_count       = 0;
      cycle_count       = 0;
      heap_size         = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part.
      test_remove_when_empty();
      test_value_extremes();
      test_equal_values();

      // Random part, with idle bursts on both sides.
      test_fill_and_drain();
      test_random_mix(240);
      test_fill_and_drain();

      // The last stretch runs with both sides always ready.
      idle_enable = 1'b0;
      test_random_mix(140);

      req_bus.valid <= 1'b0;
      while (predicted_replies.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_WAIT) @(posedge clock);
      if (error_count == 0 && predicted_replies.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
